/* rtl/psrm_pkg.sv */
package psrm_pkg;

   localparam int SLOTS_DEFAULT     = 16;
   localparam int CORES_DEFAULT     = 2;
   localparam int ITEM_BITS_DEFAULT = 32;

   localparam int ACTION_BITS    = 2;
   localparam int SOURCE_BITS    = 1;
   localparam int ITEM_WORD_BITS = 32;

   // req_tdata: action, source_core, item_in; padded to whole bytes
   localparam int REQ_FIELD_BITS = ACTION_BITS + SOURCE_BITS + ITEM_WORD_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   // rsp_tdata: ok, item_out; padded to whole bytes
   localparam int RSP_FIELD_BITS = 1 + ITEM_WORD_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_POST    = 2'd0,
      ACT_CONSUME = 2'd1,
      ACT_FLUSH   = 2'd2
   } action_type;

endpackage

/* rtl/per_source_ring_mailbox.sv */
// Mailbox with one circular queue per source core, SLOTS entries each, one slot
// always left free so a queue holds SLOTS-1 items. A post writes into the queue
// of its source core (ok=0 when full or the core does not exist); a consume
// returns the oldest item of the lowest-numbered non-empty queue (ok=0 and a zero
// word when all are empty); a flush empties every queue. All queues share one
// single-port item memory of CORES*SLOTS words with registered read data; the
// read and write indexes sit in flops. Each request makes exactly one response,
// which appears in the cycle after the request is taken. One request is taken per
// cycle while the receiver accepts responses, as the memory sees at most one access
// per request; a new request is taken while the previous response is being accepted.
// An unknown action gets ok=0 and a zero word. No clearing pass is needed after reset.
module per_source_ring_mailbox #(
   parameter int SLOTS     = psrm_pkg::SLOTS_DEFAULT,
   parameter int CORES     = psrm_pkg::CORES_DEFAULT,
   parameter int ITEM_BITS = psrm_pkg::ITEM_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [1:0] action, [2] source_core, [34:3] item_in, rest zero
   input  logic [psrm_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] ok, [32:1] item_out, rest zero
   output logic [psrm_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CORE_W = (CORES > 1) ? $clog2(CORES) : 1;
   // wide enough to hold CORES itself for the range check
   localparam int CNT_W  = $clog2(CORES + 1);
   localparam int SRC_W  = (CNT_W > psrm_pkg::SOURCE_BITS) ? CNT_W : psrm_pkg::SOURCE_BITS;
   localparam int ADDR_W = $clog2(CORES * SLOTS);
   localparam int DEPTH  = CORES * SLOTS;

   logic [ITEM_BITS-1:0] item_store_mem [DEPTH];

   logic [IDX_W-1:0] wr_idx_ff [CORES];
   logic [IDX_W-1:0] wr_idx_in [CORES];
   logic [IDX_W-1:0] rd_idx_ff [CORES];
   logic [IDX_W-1:0] rd_idx_in [CORES];

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 ok_ff, ok_in;
   logic                 take_ff, take_in;   // response carries the memory read word
   logic [ITEM_BITS-1:0] rd_data_ff;

   logic                            accept;
   psrm_pkg::action_type            action;
   logic [psrm_pkg::SOURCE_BITS-1:0] source_core;
   logic [psrm_pkg::ITEM_WORD_BITS-1:0] item_in;
   logic [SRC_W-1:0]                src_ext;
   logic [CORE_W-1:0]               post_core;
   logic [IDX_W-1:0]                post_next;
   logic                            post_ok;
   logic [CORE_W-1:0]               pick_core;
   logic                            pick_found;
   logic [IDX_W-1:0]                pick_next;
   logic                            mem_we, mem_re;
   logic [ADDR_W-1:0]               mem_addr;
   logic [ITEM_BITS-1:0]            mem_wdata;
   logic [psrm_pkg::ITEM_WORD_BITS-1:0] item_out;

   function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] nxt;
      if (idx == IDX_W'(SLOTS - 1)) begin
         nxt = '0;
      end else begin
         nxt = idx + IDX_W'(1);
      end
      return nxt;
   endfunction

   assign accept      = req_tvalid && req_tready;
   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign action      = psrm_pkg::action_type'(req_tdata[psrm_pkg::ACTION_BITS-1:0]);
   assign source_core = req_tdata[psrm_pkg::ACTION_BITS +: psrm_pkg::SOURCE_BITS];
   assign item_in     = req_tdata[psrm_pkg::ACTION_BITS + psrm_pkg::SOURCE_BITS +:
                                  psrm_pkg::ITEM_WORD_BITS];

   assign src_ext   = SRC_W'(source_core);
   assign post_core = CORE_W'(src_ext);
   assign post_next = advance(wr_idx_ff[post_core]);
   assign post_ok   = (src_ext < SRC_W'(CORES)) && (post_next != rd_idx_ff[post_core]);
   assign mem_wdata = ITEM_BITS'({{ITEM_BITS{1'b0}}, item_in});

   // fixed priority: lowest-numbered non-empty queue wins
   always_comb begin
      pick_core  = '0;
      pick_found = 1'b0;
      for (int q = CORES - 1; q >= 0; q--) begin
         if (rd_idx_ff[q] != wr_idx_ff[q]) begin
            pick_core  = CORE_W'(q);
            pick_found = 1'b1;
         end
      end
   end

   assign pick_next = advance(rd_idx_ff[pick_core]);

   always_comb begin
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ok_in        = ok_ff;
      take_in      = take_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = ADDR_W'(post_core) * ADDR_W'(SLOTS) + ADDR_W'(wr_idx_ff[post_core]);
      if (accept) begin
         rsp_valid_in = 1'b1;
         ok_in        = 1'b0;
         take_in      = 1'b0;
         case (action)
            psrm_pkg::ACT_POST: begin
               if (post_ok) begin
                  mem_we               = 1'b1;
                  wr_idx_in[post_core] = post_next;
                  ok_in                = 1'b1;
               end
            end
            psrm_pkg::ACT_CONSUME: begin
               mem_addr = ADDR_W'(pick_core) * ADDR_W'(SLOTS)
                          + ADDR_W'(rd_idx_ff[pick_core]);
               if (pick_found) begin
                  mem_re               = 1'b1;
                  rd_idx_in[pick_core] = pick_next;
                  ok_in                = 1'b1;
                  take_in              = 1'b1;
               end
            end
            psrm_pkg::ACT_FLUSH: begin
               for (int q = 0; q < CORES; q++) begin
                  wr_idx_in[q] = '0;
                  rd_idx_in[q] = '0;
               end
               ok_in = 1'b1;
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         item_store_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= item_store_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         ok_ff        <= 1'b0;
         take_ff      <= 1'b0;
         for (int q = 0; q < CORES; q++) begin
            wr_idx_ff[q] <= '0;
            rd_idx_ff[q] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         ok_ff        <= ok_in;
         take_ff      <= take_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
      end
   end

   assign item_out   = take_ff ? psrm_pkg::ITEM_WORD_BITS'({{psrm_pkg::ITEM_WORD_BITS{1'b0}},
                                                             rd_data_ff})
                               : '0;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = psrm_pkg::RSP_DATA_BITS'({item_out, ok_ff});

endmodule

/* test/tb_per_source_ring_mailbox.sv */
`timescale 1ns / 100ps

module tb_per_source_ring_mailbox;

   localparam int SLOTS = psrm_pkg::SLOTS_DEFAULT;
   localparam int CORES = psrm_pkg::CORES_DEFAULT;
   localparam int ACT_W = psrm_pkg::ACTION_BITS;
   localparam int WORD_W = psrm_pkg::ITEM_WORD_BITS;
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic              ok;
      logic [WORD_W-1:0] word;
   } mail_answer_type;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   // [1:0] action, [2] source_core, [34:3] item_in, rest zero
   logic [psrm_pkg::REQ_DATA_BITS-1:0] req_tdata;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   // [0] ok, [32:1] item_out, rest zero
   logic [psrm_pkg::RSP_DATA_BITS-1:0] rsp_tdata;

   // mirror of the mailbox
   logic [WORD_W-1:0] ring_words [CORES][SLOTS];
   logic [3:0]        post_idx [CORES];
   logic [3:0]        take_idx [CORES];

   mail_answer_type mailbox_answers [$];
   mail_answer_type oldest_answer;
   int              errors = 0;
   bit              idle_on = 1'b1;
   int              holdoff_cycles = 0;

   per_source_ring_mailbox dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [3:0] ring_next(input logic [3:0] idx);
      return (idx == SLOTS - 1) ? 4'd0 : idx + 4'd1;
   endfunction

   function automatic mail_answer_type mailbox_answer_for(input logic [ACT_W-1:0] act,
                                                          input logic src,
                                                          input logic [WORD_W-1:0] word);
      mail_answer_type ans;
      logic [3:0]      nxt;
      bit              found;
      ans   = '0;
      found = 1'b0;
      case (act)
         psrm_pkg::ACT_POST: begin
            nxt = ring_next(post_idx[src]);
            if (nxt != take_idx[src]) begin
               ring_words[src][post_idx[src]] = word;
               post_idx[src] = nxt;
               ans.ok = 1'b1;
            end
         end
         psrm_pkg::ACT_CONSUME: begin
            // lowest-numbered non-empty queue wins
            for (int q = 0; q < CORES; q++) begin
               if (!found && take_idx[q] != post_idx[q]) begin
                  ans.word    = ring_words[q][take_idx[q]];
                  take_idx[q] = ring_next(take_idx[q]);
                  ans.ok      = 1'b1;
                  found       = 1'b1;
               end
            end
         end
         psrm_pkg::ACT_FLUSH: begin
            for (int q = 0; q < CORES; q++) begin
               post_idx[q] = '0;
               take_idx[q] = '0;
            end
            ans.ok = 1'b1;
         end
         default: ans = '0;
      endcase
      return ans;
   endfunction

   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(input logic [ACT_W-1:0] act, input logic src,
                            input logic [WORD_W-1:0] word);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(psrm_pkg::REQ_DATA_BITS - psrm_pkg::REQ_FIELD_BITS){1'b0}},
                     word, src, act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      mailbox_answers.push_back(mailbox_answer_for(act, src, word));
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (mailbox_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holdoff_cycles > 0) begin
            rsp_tready <= 1'b0;
            while (holdoff_cycles > 0) begin
               @(posedge clock);
               holdoff_cycles--;
            end
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (mailbox_answers.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            oldest_answer = mailbox_answers.pop_front();
            if (rsp_tdata[0] !== oldest_answer.ok) begin
               $display("%0t: ok mismatch, expected %0b, actual %0b",
                        $time, oldest_answer.ok, rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[WORD_W:1] !== oldest_answer.word) begin
               $display("%0t: item_out mismatch, expected %h, actual %h",
                        $time, oldest_answer.word, rsp_tdata[WORD_W:1]);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      send_item(psrm_pkg::ACT_POST, 1'b0, 32'h0000_0000);
      send_item(psrm_pkg::ACT_POST, 1'b1, 32'hFFFF_FFFF);
      send_item(psrm_pkg::ACT_POST, 1'b0, 32'hAAAA_AAAA);
      send_item(psrm_pkg::ACT_POST, 1'b1, 32'h5555_5555);
      // queue 0 drains before queue 1
      send_item(psrm_pkg::ACT_CONSUME, 1'b1, 32'h1234_5678);
      send_item(psrm_pkg::ACT_CONSUME, 1'b0, 32'h0);
      send_item(psrm_pkg::ACT_CONSUME, 1'b0, 32'h0);
      send_item(psrm_pkg::ACT_CONSUME, 1'b0, 32'h0);
      // all empty
      send_item(psrm_pkg::ACT_CONSUME, 1'b1, 32'hFFFF_FFFF);
      send_item(ACT_UNUSED, 1'b1, 32'hFFFF_FFFF);
      send_item(ACT_UNUSED, 1'b0, 32'h0);
      send_item(psrm_pkg::ACT_POST, 1'b1, 32'hDEAD_BEEF);
      send_item(psrm_pkg::ACT_POST, 1'b0, 32'h8000_0001);
      send_item(psrm_pkg::ACT_FLUSH, 1'b1, 32'hFFFF_FFFF);
      send_item(psrm_pkg::ACT_CONSUME, 1'b0, 32'h0);
      send_item(psrm_pkg::ACT_POST, 1'b0, 32'h0000_0001);
      send_item(psrm_pkg::ACT_FLUSH, 1'b0, 32'h0);
      send_item(psrm_pkg::ACT_FLUSH, 1'b0, 32'h0);
      send_item(psrm_pkg::ACT_CONSUME, 1'b0, 32'h0);
      wait_for_drain();
   endtask

   task automatic test_queue_full();
      for (int c = 0; c < CORES; c++) begin
         // one post past capacity is refused
         repeat (SLOTS) send_item(psrm_pkg::ACT_POST, c[0], random_word());
      end
      repeat (CORES * SLOTS)
         send_item(psrm_pkg::ACT_CONSUME, 1'($urandom_range(0, 1)), random_word());
      // full queue 1 behind an empty queue 0, then a flush while full
      repeat (SLOTS) send_item(psrm_pkg::ACT_POST, 1'b1, random_word());
      send_item(psrm_pkg::ACT_POST, 1'b0, random_word());
      send_item(psrm_pkg::ACT_CONSUME, 1'b1, random_word());
      send_item(psrm_pkg::ACT_FLUSH, 1'($urandom_range(0, 1)), random_word());
      send_item(psrm_pkg::ACT_CONSUME, 1'b0, random_word());
      wait_for_drain();
   endtask

   task automatic test_receiver_holdoff();
      holdoff_cycles = 300;
      repeat (40) begin
         if ($urandom_range(0, 2) == 0)
            send_item(psrm_pkg::ACT_CONSUME, 1'($urandom_range(0, 1)), random_word());
         else
            send_item(psrm_pkg::ACT_POST, 1'($urandom_range(0, 1)), random_word());
      end
      wait_for_drain();
   endtask

   task automatic test_random_traffic(input int count);
      int               post_pct;
      int               pick;
      logic [ACT_W-1:0] act;
      post_pct = 50;
      for (int n = 0; n < count; n++) begin
         // bias changes in phases so queues both fill and run dry
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0:       post_pct = 75;
               1:       post_pct = 25;
               default: post_pct = 50;
            endcase
         end
         pick = $urandom_range(0, 99);
         if (pick < 3)
            act = psrm_pkg::ACT_FLUSH;
         else if (pick < 6)
            act = ACT_UNUSED;
         else if ($urandom_range(0, 99) < post_pct)
            act = psrm_pkg::ACT_POST;
         else
            act = psrm_pkg::ACT_CONSUME;
         send_item(act, 1'($urandom_range(0, 1)), random_word());
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      for (int c = 0; c < CORES; c++) begin
         post_idx[c] = '0;
         take_idx[c] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_queue_full();
      test_receiver_holdoff();
      test_random_traffic(1150);
      wait_for_drain();
      idle_on = 1'b0;
      test_random_traffic(60);
      wait_for_drain();
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
